// ----- design/stli_pkg.sv -----
// Shared types, widths and codes for the sorted-table linear interpolator.
package stli_pkg;

    localparam int KEY_W       = 16;
    localparam int VAL_W       = 16;
    localparam int DIFF_W      = KEY_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int DEPTH_DEF   = 64;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 24;

    // Item opcodes; the fourth code is a no-op
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // One breakpoint as stored in the table memory
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } entry_t;

    // Write command from the sequencer to the table memory
    typedef struct packed {
        logic   en;
        entry_t data;
    } tbl_wr_t;

endpackage

// ----- design/stli_table.sv -----
// Breakpoint memory: one write port, one read port with registered read data.
module stli_table
    import stli_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic          aclk,
    input  tbl_wr_t       wr,
    input  logic [AW-1:0] wr_addr,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    // Write one entry when enabled, read one entry every cycle
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/stli_div.sv -----
// Serial restoring divider: one quotient bit per cycle, unsigned operands.
module stli_div
    import stli_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [DIFF_W-1:0] divisor,
    output logic              done,
    output logic [PROD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [DIFF_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [DIFF_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;

    logic [DIFF_W+1:0] shifted;
    logic [DIFF_W+1:0] diff;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        shifted   = {1'b0, rem_reg, quo_reg[PROD_W-1]};
        diff      = shifted - {2'b00, div_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            div_next = divisor;
            cnt_next = CNT_W'(PROD_W);
            run_next = 1'b1;
        end else if (run_reg) begin
            if (!diff[DIFF_W+1]) begin
                rem_next = diff[DIFF_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIFF_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state; operands need no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- design/sorted_table_linear_interpolator_top.sv -----
// Top level: sequencer for load, query and clear over the breakpoint table.
//
//  channel   direction  fields (lowest bit first)
//  s_*       in         opcode[1:0], key_angle[17:2], entry_value[33:18]
//  m_*       out        result_value[15:0], status[17:16], exact_match[18]
//
// Clear, no-op, a load into a full table and a query of an empty one go straight to the
// result; a load moves each entry above the new key up one place, and a query visits the
// entries in order and, when the key falls between two, interpolates (multiply, start
// the divider, divide). After reset the table is empty; stored entries are
// never cleared, only the entry count. s_tready is high only while idle; a finished
// result waits in the output register, and a stalled sink holds the next in its result state.
module sorted_table_linear_interpolator_top
    import stli_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // opcode[1:0], key_angle[17:2], entry_value[33:18], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // result_value[15:0], status[17:16], exact_match[18], zero fill
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W = PROD_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_L_RD,
        S_L_CMP,
        S_L_PUT,
        S_Q_RD,
        S_Q_CMP,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    entry_t                  lo_reg, lo_next;
    entry_t                  hi_reg, hi_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [DIFF_W-1:0]       den_reg, den_next;
    logic [VAL_W-1:0]        res_val_reg, res_val_next;
    status_t                 res_st_reg, res_st_next;
    logic                    res_ex_reg, res_ex_next;
    logic                    m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]    m_data_reg, m_data_next;

    tbl_wr_t       tbl_wr;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;

    logic                     div_start;
    logic [PROD_W-1:0]        div_dividend;
    logic                     div_done;
    logic [PROD_W-1:0]        div_quo;

    logic signed [DIFF_W-1:0] dk;
    logic signed [DIFF_W-1:0] dv;
    logic signed [SUM_W-1:0]  q_signed;
    logic signed [SUM_W-1:0]  sum;
    logic [VAL_W-1:0]         sat;
    logic                     in_xfer;
    logic [1:0]               in_op;

    stli_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_table (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .wr_addr (idx_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stli_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign in_xfer = s_tvalid && s_tready;
    assign in_op   = s_tdata[1:0];

    // Differences for the interpolation product, and the dividend magnitude
    assign dk = DIFF_W'(key_reg) - DIFF_W'(lo_reg.key);
    assign dv = DIFF_W'(hi_reg.value) - DIFF_W'(lo_reg.value);
    assign div_dividend = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign div_start    = (state_reg == S_DIV_GO);

    // Restore the sign, add the lower value, saturate to 16 bits
    always_comb begin
        q_signed = prod_reg[PROD_W-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        sum      = q_signed + SUM_W'(lo_reg.value);
        if (sum > SUM_W'(32767)) begin
            sat = 16'h7FFF;
        end else if (sum < -SUM_W'(32768)) begin
            sat = 16'h8000;
        end else begin
            sat = sum[VAL_W-1:0];
        end
    end

    // Memory read address and write command
    always_comb begin
        case (state_reg)
            S_L_RD:  rd_addr = idx_reg - 1'b1;
            default: rd_addr = idx_reg;
        endcase
        tbl_wr.en   = 1'b0;
        tbl_wr.data = '{key: key_reg, value: val_reg};
        if (state_reg == S_L_PUT) begin
            tbl_wr.en = 1'b1;
        end else if (state_reg == S_L_CMP) begin
            tbl_wr.en = 1'b1;
            if (rd_data.key > key_reg) begin
                tbl_wr.data = rd_data;
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        prod_next    = prod_reg;
        den_next     = den_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;
        res_ex_next  = res_ex_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        // Drop the result once the sink takes it
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    key_next     = s_tdata[17:2];
                    val_next     = s_tdata[33:18];
                    res_val_next = '0;
                    res_st_next  = ST_OK;
                    res_ex_next  = 1'b0;
                    state_next   = S_RESP;
                    case (in_op)
                        OP_LOAD: begin
                            if (count_reg == CW'(TABLE_DEPTH)) begin
                                res_st_next = ST_FULL;
                            end else if (count_reg == '0) begin
                                idx_next   = '0;
                                state_next = S_L_PUT;
                            end else begin
                                idx_next   = AW'(count_reg);
                                state_next = S_L_RD;
                            end
                        end
                        OP_QUERY: begin
                            if (count_reg == '0) begin
                                res_st_next = ST_EMPTY;
                            end else begin
                                idx_next   = '0;
                                state_next = S_Q_RD;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_L_RD: begin
                state_next = S_L_CMP;
            end
            S_L_CMP: begin
                // Move a larger entry up one place, or drop the new one in
                if (rd_data.key > key_reg) begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = (idx_reg == AW'(1)) ? S_L_PUT : S_L_RD;
                end else begin
                    count_next = count_reg + 1'b1;
                    state_next = S_RESP;
                end
            end
            S_L_PUT: begin
                count_next = count_reg + 1'b1;
                state_next = S_RESP;
            end
            S_Q_RD: begin
                state_next = S_Q_CMP;
            end
            S_Q_CMP: begin
                if (key_reg == rd_data.key) begin
                    res_val_next = rd_data.value;
                    res_ex_next  = 1'b1;
                    state_next   = S_RESP;
                end else if (key_reg > rd_data.key) begin
                    lo_next = rd_data;
                    if (CW'(idx_reg) + 1'b1 == count_reg) begin
                        res_val_next = rd_data.value;
                        res_st_next  = ST_RANGE;
                        state_next   = S_RESP;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_Q_RD;
                    end
                end else if (idx_reg == '0) begin
                    res_val_next = rd_data.value;
                    res_st_next  = ST_RANGE;
                    state_next   = S_RESP;
                end else begin
                    hi_next    = rd_data;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                prod_next  = PROD_W'(dk) * PROD_W'(dv);
                den_next   = DIFF_W'(hi_reg.key) - DIFF_W'(lo_reg.key);
                state_next = S_DIV_GO;
            end
            S_DIV_GO: begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    res_val_next = sat;
                    state_next   = S_RESP;
                end
            end
            S_RESP: begin
                // Load the output register when it is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({res_ex_reg, res_st_reg, res_val_reg});
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg     <= idx_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        prod_reg    <= prod_next;
        den_reg     <= den_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        res_ex_reg  <= res_ex_next;
        m_data_reg  <= m_data_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
